>>> sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> sv/vevid_pkg.sv
package vevid_pkg;

	localparam int CORDIC_ITERS = 30;
	localparam int CORDIC_FRAC = 30;
	localparam int XY_W = 45;
	localparam int Z_W = 32;
	localparam int NORM_MSB = 40;
	localparam int N_W = 33;
	localparam int D_W = 24;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 32'sd1686629713;

	localparam logic [1:0] REG_PHASE_GAIN = 2'd0;
	localparam logic [1:0] REG_ORIGINAL_GAIN = 2'd1;

	typedef enum logic [1:0] {
		KIND_NORMAL,
		KIND_ZERO,
		KIND_HALF_PI
	} kind_t;

	typedef struct packed {
		logic valid;
		kind_t kind;
	} ctl_t;

	function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned i);
		logic signed [Z_W-1:0] v;
		case (i)
			0: v = 32'sd843314857;
			1: v = 32'sd497837829;
			2: v = 32'sd263043837;
			3: v = 32'sd133525159;
			4: v = 32'sd67021687;
			5: v = 32'sd33543516;
			6: v = 32'sd16775851;
			7: v = 32'sd8388437;
			8: v = 32'sd4194283;
			9: v = 32'sd2097149;
			default: v = Z_W'(32'sd1 <<< (CORDIC_FRAC - i));
		endcase
		return v;
	endfunction

endpackage

>>> sv/vevid_cordic.sv
module vevid_cordic (
	input  logic clk,
	input  logic arst_n,
	input  vevid_pkg::ctl_t ctl_in,
	input  logic signed [vevid_pkg::XY_W-1:0] x_in,
	input  logic signed [vevid_pkg::XY_W-1:0] y_in,
	output vevid_pkg::ctl_t ctl_out,
	output logic signed [vevid_pkg::Z_W-1:0] z_out
);
	localparam int NI = vevid_pkg::CORDIC_ITERS;

	logic signed [vevid_pkg::XY_W-1:0] x_s [0:NI];
	logic signed [vevid_pkg::XY_W-1:0] y_s [0:NI];
	logic signed [vevid_pkg::Z_W-1:0]  z_s [0:NI];
	vevid_pkg::ctl_t                   ctl_s [0:NI];

	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign z_s[0] = '0;
	assign ctl_s[0] = ctl_in;

	for (genvar i = 0; i < NI; i++) begin : g_iter
		logic signed [vevid_pkg::XY_W-1:0] xs, ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1].valid <= 1'b0;
				ctl_s[i+1].kind <= vevid_pkg::KIND_NORMAL;
			end else begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		// rotate toward the x axis
		always_ff @(posedge clk) begin
			if (!y_s[i][vevid_pkg::XY_W-1]) begin
				x_s[i+1] <= x_s[i] + ys;
				y_s[i+1] <= y_s[i] - xs;
				z_s[i+1] <= z_s[i] + vevid_pkg::atan_entry(i);
			end else begin
				x_s[i+1] <= x_s[i] - ys;
				y_s[i+1] <= y_s[i] + xs;
				z_s[i+1] <= z_s[i] - vevid_pkg::atan_entry(i);
			end
		end
	end

	assign ctl_out = ctl_s[NI];
	assign z_out = z_s[NI];
endmodule

>>> sv/vevid_phase_per_pixel_core.sv
// Phase of one gray pixel: phase = -atan(G*(b/x + 1)) in signed Q2.14 radians (the
// fraction width follows ANGLE_FRAC_BITS). One pixel is taken every clock; busy stays
// low. The result comes 35 cycles after start, marked by a one-cycle done strobe, and
// must be taken then. The latency is set by four setup stages (capture, gain multiply,
// leading one search, normalizing shift), one stage per CORDIC iteration (30) and the
// output register. Gains are written through the cfg port (index 0 G, index 1 b) while
// idle.
`include "assert_macros.svh"

module vevid_phase_per_pixel_core #(
	parameter int ANGLE_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [7:0] pixel,
	output logic done,
	output logic signed [15:0] phase,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int SHIFT = vevid_pkg::CORDIC_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [vevid_pkg::Z_W:0] HALF = (vevid_pkg::Z_W+1)'((64'sd1 <<< SHIFT) >>> 1);
	localparam int LATENCY = 4 + vevid_pkg::CORDIC_ITERS + 1;

	logic [15:0] phase_gain_q, original_gain_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_gain_q <= 16'd256;
			original_gain_q <= 16'd51;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vevid_pkg::REG_PHASE_GAIN: phase_gain_q <= cfg_data;
				vevid_pkg::REG_ORIGINAL_GAIN: original_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: capture pixel and gains
	vevid_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [7:0] px_s1;
	logic [15:0] g_s1, b_s1;
	vevid_pkg::kind_t kind_in;

	always_comb begin
		if (phase_gain_q == '0)
			kind_in = vevid_pkg::KIND_ZERO;
		else if (pixel == '0 && original_gain_q != '0)
			kind_in = vevid_pkg::KIND_HALF_PI;
		else
			kind_in = vevid_pkg::KIND_NORMAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, kind: vevid_pkg::KIND_NORMAL};
			ctl_s2 <= '{valid: 1'b0, kind: vevid_pkg::KIND_NORMAL};
			ctl_s3 <= '{valid: 1'b0, kind: vevid_pkg::KIND_NORMAL};
			ctl_s4 <= '{valid: 1'b0, kind: vevid_pkg::KIND_NORMAL};
		end else begin
			ctl_s1 <= '{valid: start && !busy, kind: kind_in};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= pixel;
		g_s1 <= phase_gain_q;
		b_s1 <= original_gain_q;
	end

	// stage 2: ratio N/D = G*(b + 256x) / (65536x), or G / 256 when x is 0
	logic [vevid_pkg::N_W-1:0] n_s2, n_s3;
	logic [vevid_pkg::D_W-1:0] d_s2, d_s3;
	logic [16:0] bsum;

	assign bsum = 17'(b_s1) + 17'({px_s1, 8'd0});

	always_ff @(posedge clk) begin
		if (px_s1 == '0) begin
			n_s2 <= vevid_pkg::N_W'(g_s1);
			d_s2 <= vevid_pkg::D_W'(256);
		end else begin
			n_s2 <= vevid_pkg::N_W'(g_s1) * vevid_pkg::N_W'(bsum);
			d_s2 <= {px_s1, 16'd0};
		end
	end

	// stage 3: leading one of the larger term
	logic [vevid_pkg::N_W-1:0] mx;
	logic [5:0] msb;
	logic [5:0] k_s3;

	assign mx = (n_s2 > vevid_pkg::N_W'(d_s2)) ? n_s2 : vevid_pkg::N_W'(d_s2);

	always_comb begin
		msb = '0;
		for (int j = 0; j < vevid_pkg::N_W; j++)
			if (mx[j]) msb = 6'(j);
	end

	always_ff @(posedge clk) begin
		n_s3 <= n_s2;
		d_s3 <= d_s2;
		k_s3 <= 6'(vevid_pkg::NORM_MSB) - msb;
	end

	// stage 4: normalize both terms
	logic signed [vevid_pkg::XY_W-1:0] x_s4, y_s4;

	always_ff @(posedge clk) begin
		x_s4 <= vevid_pkg::XY_W'({21'd0, d_s3} << k_s3);
		y_s4 <= vevid_pkg::XY_W'({12'd0, n_s3} << k_s3);
	end

	vevid_pkg::ctl_t ctl_c;
	logic signed [vevid_pkg::Z_W-1:0] z_c;

	vevid_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s4),
		.x_in    (x_s4),
		.y_in    (y_s4),
		.ctl_out (ctl_c),
		.z_out   (z_c)
	);

	// select the special cases, round, negate and saturate
	logic signed [vevid_pkg::Z_W-1:0] z_sel;
	logic signed [vevid_pkg::Z_W:0] r;
	logic signed [vevid_pkg::Z_W+1:0] neg;
	logic signed [15:0] phase_q;
	logic done_q;

	always_comb begin
		case (ctl_c.kind)
			vevid_pkg::KIND_ZERO: z_sel = '0;
			vevid_pkg::KIND_HALF_PI: z_sel = vevid_pkg::HALF_PI_Q30;
			default: z_sel = z_c;
		endcase
		r = ((vevid_pkg::Z_W+1)'(z_sel) + HALF) >>> SHIFT;
		neg = -((vevid_pkg::Z_W+2)'(r));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= ctl_c.valid;
	end

	always_ff @(posedge clk) begin
		if (neg < -34'sd32768)
			phase_q <= -16'sd32768;
		else if (neg > 34'sd32767)
			phase_q <= 16'sd32767;
		else
			phase_q <= 16'(neg);
	end

	assign done = done_q;
	assign phase = phase_q;

	`ASSERT_PROP(a_latency, clk, arst_n, (start && !busy) |-> ##LATENCY done, "result missing after fixed latency")
	`ASSERT_NEVER(a_sign, clk, arst_n, done && (phase > 16'sd0), "phase must not be positive")
	`ASSERT_PROP(a_zero_gain, clk, arst_n, (ctl_c.valid && ctl_c.kind == vevid_pkg::KIND_ZERO) |=> (phase == 16'sd0), "zero gain must give zero phase")
endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 14;
	localparam int LATENCY = 35;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [7:0] pixel;
	logic done;
	logic signed [15:0] phase;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	logic [15:0] gain_g;
	logic [15:0] gain_b;
	logic signed [15:0] expected_phase[$];
	int errors;
	longint cycles;

	vevid_phase_per_pixel_core #(.ANGLE_FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .phase(phase), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint arctan_q30(input longint n, input longint d);
		longint x, y, z, xs, ys;
		longint angle;
		x = d;
		y = n;
		z = 0;
		while ((x > y ? x : y) < (64'sd1 << 40)) begin
			x = x <<< 1;
			y = y <<< 1;
		end
		for (int i = 0; i < 30; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			case (i)
				0: angle = 843314857;
				1: angle = 497837829;
				2: angle = 263043837;
				3: angle = 133525159;
				4: angle = 67021687;
				5: angle = 33543516;
				6: angle = 16775851;
				7: angle = 8388437;
				8: angle = 4194283;
				9: angle = 2097149;
				default: angle = 64'sd1 <<< (30 - i);
			endcase
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + angle;
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - angle;
			end
		end
		return z;
	endfunction

	function automatic logic signed [15:0] pixel_phase(input logic [7:0] px);
		longint g, b, x, z, mag, ph;
		int s;
		g = gain_g;
		b = gain_b;
		x = px;
		s = 30 - FRAC;
		if (g == 0)
			z = 0;
		else if (x == 0)
			z = (b == 0) ? arctan_q30(g, 256) : 64'sd1686629713;
		else
			z = arctan_q30(g * (b + 256 * x), 65536 * x);
		mag = (g == 0) ? 0 : ((z + ((64'sd1 <<< s) >>> 1)) >>> s);
		ph = -mag;
		if (ph < -32768)
			ph = -32768;
		if (ph > 32767)
			ph = 32767;
		return ph[15:0];
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// one result per strobe, receiver cannot stall
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_phase.size() == 0) begin
				$display("%0t: unexpected result phase=%0d", $time, phase);
				errors++;
			end else begin
				if (phase !== expected_phase[0]) begin
					$display("%0t: phase expected %0d actual %0d", $time,
						expected_phase[0], phase);
					errors++;
				end
				void'(expected_phase.pop_front());
			end
		end
	end

	task automatic send_pixel(input logic [7:0] px);
		start = 1'b1;
		pixel = px;
		do @(posedge clk); while (busy);
		expected_phase.push_back(pixel_phase(px));
		@(negedge clk);
		start = 1'b0;
	endtask

	// burst sender: keeps start high across a burst, random gaps between bursts
	task automatic send_burst(input int count, input bit random_px, input logic [7:0] fixed);
		for (int k = 0; k < count; k++) begin
			logic [7:0] px;
			px = random_px ? 8'($urandom) : fixed;
			if ($urandom_range(0, 7) == 0)
				px = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'hff;
			start = 1'b1;
			pixel = px;
			do @(posedge clk); while (busy);
			expected_phase.push_back(pixel_phase(px));
			@(negedge clk);
		end
		start = 1'b0;
		repeat ($urandom_range(0, 6)) @(negedge clk);
	endtask

	task automatic wait_drained();
		while (expected_phase.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic write_gain(input logic [1:0] idx, input logic [15:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == vevid_pkg::REG_PHASE_GAIN)
			gain_g = value;
		else
			gain_b = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_gains(input logic [15:0] g, input logic [15:0] b);
		wait_drained();
		write_gain(vevid_pkg::REG_PHASE_GAIN, g);
		write_gain(vevid_pkg::REG_ORIGINAL_GAIN, b);
	endtask

	task automatic test_reset_gains();
		send_pixel(8'd0);
		send_pixel(8'd1);
		send_pixel(8'd128);
		send_pixel(8'hff);
		send_pixel(8'h55);
		send_pixel(8'haa);
	endtask

	task automatic test_special_cases();
		// zero gain, zero pixel with positive gains, zero pixel with b zero
		set_gains(16'd0, 16'd51);
		send_pixel(8'd0);
		send_pixel(8'hff);
		set_gains(16'hffff, 16'hffff);
		send_pixel(8'd0);
		send_pixel(8'd1);
		send_pixel(8'hff);
		set_gains(16'd1, 16'd0);
		send_pixel(8'd0);
		send_pixel(8'hff);
		set_gains(16'hffff, 16'd0);
		send_pixel(8'd0);
		send_pixel(8'd7);
		set_gains(16'd1, 16'hffff);
		send_pixel(8'd0);
		send_pixel(8'd1);
		send_pixel(8'hff);
	endtask

	task automatic test_random_phases(input int total);
		int sent;
		int next_cfg;
		sent = 0;
		next_cfg = 0;
		while (sent < total) begin
			int n;
			if (sent >= next_cfg) begin
				next_cfg += 200;
				case ($urandom_range(0, 3))
					0: set_gains(16'($urandom), 16'($urandom));
					1: set_gains(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 255)));
					2: set_gains(16'($urandom_range(0, 1) ? 16'hffff : 16'd0),
						16'($urandom));
					default: set_gains(16'($urandom), 16'($urandom_range(0, 1) ? 0 : 16'hffff));
				endcase
			end
			n = $urandom_range(1, 24);
			send_burst(n, 1'b1, 8'd0);
			sent += n;
			if (sent % 7 == 0)
				repeat ($urandom_range(20, 60)) @(negedge clk);
		end
	endtask

	task automatic test_drain_pause();
		send_burst(10, 1'b1, 8'd0);
		while (expected_phase.size() != 0)
			@(negedge clk);
		send_burst(10, 1'b1, 8'd0);
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		gain_g = 16'd256;
		gain_b = 16'd51;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = vevid_pkg::REG_PHASE_GAIN;
		cfg_data = 16'd0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_gains();
		test_special_cases();
		set_gains(16'd256, 16'd51);
		test_drain_pause();
		test_random_phases(1200);
		wait_drained();
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
